@@ hdl/lpc_pkg.sv @@
// Shared types and constants for the LED pixel correction pipeline.
// Holds the built-in gamma 2.2 curve, worked out at elaboration.
// No dependencies.
`timescale 1ns / 1ps

package lpc_pkg;

	localparam int CHAN_W      = 8;
	localparam int GAMMA_DEPTH = 256;
	localparam int GAMMA_AW    = 8;
	localparam int CFG_IDX_W   = 3;
	localparam int CFG_DATA_W  = 8;
	localparam int ENABLE_W    = 4;
	localparam int PCT_W       = 7;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_STAGE_ENABLES   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_BRIGHTNESS  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_THRESHOLD = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_WHITE_TARGET    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_GREEN_PERCENT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_BLUE_PERCENT    = 3'd5;

	// Bits of stage_enables.
	localparam int EN_CLAMP = 0;
	localparam int EN_WHITE = 1;
	localparam int EN_BROWN = 2;
	localparam int EN_GAMMA = 3;

	localparam logic [ENABLE_W-1:0] RST_STAGE_ENABLES   = 4'd11;
	localparam logic [CHAN_W-1:0]   RST_MAX_BRIGHTNESS  = 8'd255;
	localparam logic [CHAN_W-1:0]   RST_WHITE_THRESHOLD = 8'd150;
	localparam logic [CHAN_W-1:0]   RST_WHITE_TARGET    = 8'd100;
	localparam logic [PCT_W-1:0]    RST_GREEN_PERCENT   = 7'd28;
	localparam logic [PCT_W-1:0]    RST_BLUE_PERCENT    = 7'd8;

	localparam logic [CHAN_W-1:0] CHAN_MAX     = 8'd255;
	localparam logic [CHAN_W-1:0] WHITE_SPREAD = 8'd40;

	// floor(x / 100) equals (x * 5243) >> 19 for every x below 43690.
	localparam int PROD_W       = CHAN_W + PCT_W;
	localparam int DIV100_MUL_W = 13;
	localparam int DIV100_SHIFT = 19;
	localparam logic [DIV100_MUL_W-1:0] DIV100_MUL = 13'd5243;
	localparam int CAP_W = PROD_W + DIV100_MUL_W - DIV100_SHIFT;

	typedef struct packed {
		logic              kind;
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              fe;
		logic [CHAN_W-1:0] idx;
		logic [CHAN_W-1:0] val;
	} item_t;

	typedef struct packed {
		logic                en;
		logic [GAMMA_AW-1:0] addr;
		logic [CHAN_W-1:0]   data;
	} gamma_wr_t;

	typedef logic [CHAN_W-1:0] gamma_rom_t [GAMMA_DEPTH];

	// Entry i counts the k in 1..255 with (2k-1)^5 * 255^6 <= 32 * i^11,
	// which is round(255 * (i/255)^2.2) with halves rounded up.
	function automatic gamma_rom_t build_gamma();
		gamma_rom_t  rom;
		logic [127:0] lhs;
		logic [127:0] rhs;
		int unsigned k;
		int unsigned i;
		int unsigned n;
		logic        done;
		rom[0] = '0;
		k = 0;
		for (i = 1; i < GAMMA_DEPTH; i++) begin
			lhs = 128'd32;
			for (n = 0; n < 11; n++)
				lhs = lhs * 128'(i);
			done = 1'b0;
			while (k < 255 && !done) begin
				rhs = 128'd274941996890625;
				for (n = 0; n < 5; n++)
					rhs = rhs * 128'(2 * k + 1);
				if (rhs <= lhs)
					k = k + 1;
				else
					done = 1'b1;
			end
			rom[i] = CHAN_W'(k);
		end
		return rom;
	endfunction

	localparam gamma_rom_t GAMMA_ROM = build_gamma();

endpackage

@@ hdl/lpc_if.sv @@
// Channel interfaces of the pixel correction pipeline: pixel input,
// corrected pixel output and configuration writes. Uses lpc_pkg.
`timescale 1ns / 1ps

interface lpc_in_if;
	logic                      valid;
	logic                      ready;
	logic                      kind;
	logic [lpc_pkg::CHAN_W-1:0] red_in;
	logic [lpc_pkg::CHAN_W-1:0] green_in;
	logic [lpc_pkg::CHAN_W-1:0] blue_in;
	logic                      frame_end_in;
	logic [lpc_pkg::CHAN_W-1:0] table_index;
	logic [lpc_pkg::CHAN_W-1:0] table_value;

	modport source (output valid, kind, red_in, green_in, blue_in, frame_end_in,
		table_index, table_value, input ready);
	modport sink (input valid, kind, red_in, green_in, blue_in, frame_end_in,
		table_index, table_value, output ready);
endinterface

interface lpc_out_if;
	logic                      valid;
	logic                      ready;
	logic [lpc_pkg::CHAN_W-1:0] red_out;
	logic [lpc_pkg::CHAN_W-1:0] green_out;
	logic [lpc_pkg::CHAN_W-1:0] blue_out;
	logic                      frame_end_out;

	modport source (output valid, red_out, green_out, blue_out, frame_end_out,
		input ready);
	modport sink (input valid, red_out, green_out, blue_out, frame_end_out,
		output ready);
endinterface

interface lpc_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [lpc_pkg::CFG_IDX_W-1:0]  index;
	logic [lpc_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

@@ hdl/led_pixel_correction_pipeline.sv @@
// Top level of the LED pixel correction pipeline: configuration registers,
// stage registers and output register. Uses lpc_pkg, lpc_if, lpc_div, lpc_gamma.
//
//   port       dir  handshake      word
//   pixel_in   in   valid/ready    pixel or gamma table write
//   pixel_out  out  valid/ready    corrected pixel
//   cfg        in   valid/ready    register index and value, always ready
//
// One word enters per cycle unless the pipe is frozen; an accepted pixel passes
// through stage registers s1 to s8 and then into the output register.
// Table writes take effect at the gamma read stage, so they stay in order
// with pixels around them and produce no output word.
// Reset clears control state only; gamma entries read the built-in curve
// until written, so there is no clearing pass.
// The pipe freezes only while the output word waits and the last stage is full.
`timescale 1ns / 1ps

module led_pixel_correction_pipeline (
	input  logic      clk,
	input  logic      arst_n,
	lpc_in_if.sink    pixel_in,
	lpc_out_if.source pixel_out,
	lpc_cfg_if.sink   cfg
);

	localparam int W = lpc_pkg::CHAN_W;

	logic [lpc_pkg::ENABLE_W-1:0] stage_en_q;
	logic [W-1:0]                 max_bright_q;
	logic [W-1:0]                 white_thr_q;
	logic [W-1:0]                 white_tgt_q;
	logic [lpc_pkg::PCT_W-1:0]    green_pct_q;
	logic [lpc_pkg::PCT_W-1:0]    blue_pct_q;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8;
	lpc_pkg::item_t item_s1, item_s2, item_s3, item_s4;
	lpc_pkg::item_t item_s5, item_s6, item_s7, item_s8;
	logic [W-1:0] mx_s1;
	logic hit_s1, hit_s2, hit_s3;
	logic brown_s6;
	logic [lpc_pkg::PROD_W-1:0] pg_s6, pb_s6;

	logic out_valid_q;
	logic [W-1:0] red_q, green_q, blue_q;
	logic fe_q;

	logic adv;
	logic in_take;
	lpc_pkg::item_t in_item, nx4, nx5, nx7;
	logic [W-1:0] in_mx, quo;
	logic [2*W-1:0] pr, pgr, pbl;
	logic [W-1:0] mn5, mx5, d5;
	logic white_hit;
	logic brown_nx;
	logic [lpc_pkg::PROD_W-1:0] pg_nx, pb_nx;
	logic [lpc_pkg::PROD_W+lpc_pkg::DIV100_MUL_W-1:0] qg_p, qb_p;
	logic [lpc_pkg::CAP_W-1:0] capg_w, capb_w;
	logic [W-1:0] capg, capb;
	logic [2:0][lpc_pkg::GAMMA_AW-1:0] g_addr;
	logic [2:0][W-1:0] g_data;
	lpc_pkg::gamma_wr_t g_wr;

	// The pipe moves unless the output word is held and the last stage is full.
	assign adv = pixel_out.ready || !out_valid_q || !v_s8;
	assign pixel_in.ready = adv;
	assign in_take = pixel_in.valid && adv;
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_en_q   <= lpc_pkg::RST_STAGE_ENABLES;
			max_bright_q <= lpc_pkg::RST_MAX_BRIGHTNESS;
			white_thr_q  <= lpc_pkg::RST_WHITE_THRESHOLD;
			white_tgt_q  <= lpc_pkg::RST_WHITE_TARGET;
			green_pct_q  <= lpc_pkg::RST_GREEN_PERCENT;
			blue_pct_q   <= lpc_pkg::RST_BLUE_PERCENT;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				lpc_pkg::REG_STAGE_ENABLES:   stage_en_q   <= cfg.data[lpc_pkg::ENABLE_W-1:0];
				lpc_pkg::REG_MAX_BRIGHTNESS:  max_bright_q <= cfg.data;
				lpc_pkg::REG_WHITE_THRESHOLD: white_thr_q  <= cfg.data;
				lpc_pkg::REG_WHITE_TARGET:    white_tgt_q  <= cfg.data;
				lpc_pkg::REG_GREEN_PERCENT:   green_pct_q  <= cfg.data[lpc_pkg::PCT_W-1:0];
				lpc_pkg::REG_BLUE_PERCENT:    blue_pct_q   <= cfg.data[lpc_pkg::PCT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		in_item.kind = pixel_in.kind;
		in_item.r    = pixel_in.red_in;
		in_item.g    = pixel_in.green_in;
		in_item.b    = pixel_in.blue_in;
		in_item.fe   = pixel_in.frame_end_in;
		in_item.idx  = pixel_in.table_index;
		in_item.val  = pixel_in.table_value;
		in_mx = pixel_in.red_in > pixel_in.green_in ? pixel_in.red_in : pixel_in.green_in;
		if (pixel_in.blue_in > in_mx)
			in_mx = pixel_in.blue_in;
	end

	lpc_div u_div (
		.clk    (clk),
		.en     (adv),
		.num_hi (max_bright_q),
		.den    (mx_s1),
		.quo    (quo)
	);

	// Brightness clamp: scale by the 0.8 ratio from the divider.
	always_comb begin
		pr  = item_s3.r * quo;
		pgr = item_s3.g * quo;
		pbl = item_s3.b * quo;
		nx4 = item_s3;
		if (hit_s3) begin
			nx4.r = pr[2*W-1:W];
			nx4.g = pgr[2*W-1:W];
			nx4.b = pbl[2*W-1:W];
		end
	end

	// White reduction.
	always_comb begin
		mn5 = item_s4.r < item_s4.g ? item_s4.r : item_s4.g;
		if (item_s4.b < mn5)
			mn5 = item_s4.b;
		mx5 = item_s4.r > item_s4.g ? item_s4.r : item_s4.g;
		if (item_s4.b > mx5)
			mx5 = item_s4.b;
		d5 = mn5 - white_tgt_q;
		white_hit = stage_en_q[lpc_pkg::EN_WHITE] && (mn5 > white_thr_q)
			&& ((mx5 - mn5) < lpc_pkg::WHITE_SPREAD) && (mn5 > white_tgt_q);
		nx5 = item_s4;
		if (white_hit) begin
			nx5.r = item_s4.r > d5 ? item_s4.r - d5 : '0;
			nx5.g = item_s4.g > d5 ? item_s4.g - d5 : '0;
			nx5.b = item_s4.b > d5 ? item_s4.b - d5 : '0;
		end
	end

	// Brown guardrail: products first, then the divide by 100 and the caps.
	always_comb begin
		brown_nx = stage_en_q[lpc_pkg::EN_BROWN] && (item_s5.r > item_s5.g)
			&& (item_s5.g >= item_s5.b);
		pg_nx = item_s5.r * green_pct_q;
		pb_nx = item_s5.r * blue_pct_q;
	end

	always_comb begin
		qg_p = pg_s6 * lpc_pkg::DIV100_MUL;
		qb_p = pb_s6 * lpc_pkg::DIV100_MUL;
		capg_w = qg_p[lpc_pkg::PROD_W+lpc_pkg::DIV100_MUL_W-1:lpc_pkg::DIV100_SHIFT];
		capb_w = qb_p[lpc_pkg::PROD_W+lpc_pkg::DIV100_MUL_W-1:lpc_pkg::DIV100_SHIFT];
		capg = capg_w > lpc_pkg::CAP_W'(lpc_pkg::CHAN_MAX) ? lpc_pkg::CHAN_MAX : capg_w[W-1:0];
		capb = capb_w > lpc_pkg::CAP_W'(lpc_pkg::CHAN_MAX) ? lpc_pkg::CHAN_MAX : capb_w[W-1:0];
		nx7 = item_s6;
		if (brown_s6) begin
			if (item_s6.g > capg)
				nx7.g = capg;
			if (item_s6.b > capb)
				nx7.b = capb;
		end
	end

	// Table writes and pixel reads meet the gamma RAM at the same stage.
	always_comb begin
		g_addr[0]  = item_s7.r;
		g_addr[1]  = item_s7.g;
		g_addr[2]  = item_s7.b;
		g_wr.en    = adv && v_s7 && item_s7.kind;
		g_wr.addr  = item_s7.idx;
		g_wr.data  = item_s7.val;
	end

	lpc_gamma u_gamma (
		.clk    (clk),
		.arst_n (arst_n),
		.re     (adv),
		.raddr  (g_addr),
		.wr     (g_wr),
		.rdata  (g_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				v_s1 <= in_take;
				v_s2 <= v_s1;
				v_s3 <= v_s2;
				v_s4 <= v_s3;
				v_s5 <= v_s4;
				v_s6 <= v_s5;
				v_s7 <= v_s6;
				v_s8 <= v_s7 && !item_s7.kind;
			end
			if (adv && v_s8)
				out_valid_q <= 1'b1;
			else if (pixel_out.ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			item_s1  <= in_item;
			mx_s1    <= in_mx;
			hit_s1   <= stage_en_q[lpc_pkg::EN_CLAMP]
				&& (max_bright_q != lpc_pkg::CHAN_MAX) && (in_mx > max_bright_q);
			item_s2  <= item_s1;
			hit_s2   <= hit_s1;
			item_s3  <= item_s2;
			hit_s3   <= hit_s2;
			item_s4  <= nx4;
			item_s5  <= nx5;
			item_s6  <= item_s5;
			brown_s6 <= brown_nx;
			pg_s6    <= pg_nx;
			pb_s6    <= pb_nx;
			item_s7  <= nx7;
			item_s8  <= item_s7;
		end
		if (adv && v_s8) begin
			if (stage_en_q[lpc_pkg::EN_GAMMA]) begin
				red_q   <= g_data[0];
				green_q <= g_data[1];
				blue_q  <= g_data[2];
			end else begin
				red_q   <= item_s8.r;
				green_q <= item_s8.g;
				blue_q  <= item_s8.b;
			end
			fe_q <= item_s8.fe;
		end
	end

	assign pixel_out.valid         = out_valid_q;
	assign pixel_out.red_out       = red_q;
	assign pixel_out.green_out     = green_q;
	assign pixel_out.blue_out      = blue_q;
	assign pixel_out.frame_end_out = fe_q;

endmodule

@@ hdl/lpc_div.sv @@
// Two-stage pipelined divider for the brightness clamp ratio:
// (num_hi * 256) / den, four restoring steps per stage. Uses lpc_pkg.
`timescale 1ns / 1ps

module lpc_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [lpc_pkg::CHAN_W-1:0] num_hi,
	input  logic [lpc_pkg::CHAN_W-1:0] den,
	output logic [lpc_pkg::CHAN_W-1:0] quo
);

	typedef struct packed {
		logic [3:0]                q;
		logic [lpc_pkg::CHAN_W-1:0] rem;
	} step_t;

	// The remainder stays below den, so each shifted value fits nine bits.
	function automatic step_t div_step4(logic [lpc_pkg::CHAN_W-1:0] rem_i,
			logic [lpc_pkg::CHAN_W-1:0] d);
		step_t             res;
		logic [lpc_pkg::CHAN_W:0] t;
		res.rem = rem_i;
		res.q   = '0;
		for (int j = 0; j < 4; j++) begin
			t = {res.rem, 1'b0};
			if (t >= {1'b0, d}) begin
				t = t - {1'b0, d};
				res.q[3 - j] = 1'b1;
			end
			res.rem = t[lpc_pkg::CHAN_W-1:0];
		end
		return res;
	endfunction

	step_t                      st_a;
	step_t                      st_b;
	logic [lpc_pkg::CHAN_W-1:0] rem_s1;
	logic [3:0]                 q_s1;
	logic [lpc_pkg::CHAN_W-1:0] den_s1;
	logic [lpc_pkg::CHAN_W-1:0] quo_s2;

	always_comb begin
		st_a = div_step4(num_hi, den);
		st_b = div_step4(rem_s1, den_s1);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s1 <= st_a.rem;
			q_s1   <= st_a.q;
			den_s1 <= den;
			quo_s2 <= {q_s1, st_b.q};
		end
	end

	assign quo = quo_s2;

endmodule

@@ hdl/lpc_gamma_ram.sv @@
// 256 x 8 synchronous RAM, one write port and one read port with
// registered read data. Uses lpc_pkg for its sizes.
`timescale 1ns / 1ps

module lpc_gamma_ram (
	input  logic                         clk,
	input  logic                         we,
	input  logic [lpc_pkg::GAMMA_AW-1:0] waddr,
	input  logic [lpc_pkg::CHAN_W-1:0]   wdata,
	input  logic                         re,
	input  logic [lpc_pkg::GAMMA_AW-1:0] raddr,
	output logic [lpc_pkg::CHAN_W-1:0]   rdata
);

	logic [lpc_pkg::CHAN_W-1:0] mem [lpc_pkg::GAMMA_DEPTH];
	logic [lpc_pkg::CHAN_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ hdl/lpc_gamma.sv @@
// Gamma lookup: one RAM copy per channel, valid bits per entry and the
// built-in curve for entries never written. Uses lpc_pkg, lpc_gamma_ram.
`timescale 1ns / 1ps

module lpc_gamma (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                re,
	input  logic [2:0][lpc_pkg::GAMMA_AW-1:0]   raddr,
	input  lpc_pkg::gamma_wr_t                  wr,
	output logic [2:0][lpc_pkg::CHAN_W-1:0]     rdata
);

	logic [lpc_pkg::GAMMA_DEPTH-1:0]  valid_q;
	logic [2:0]                       hit_q;
	logic [2:0][lpc_pkg::CHAN_W-1:0]  rom_q;
	logic [2:0][lpc_pkg::CHAN_W-1:0]  ram_data;

	for (genvar c = 0; c < 3; c++) begin : g_chan
		lpc_gamma_ram u_ram (
			.clk   (clk),
			.we    (wr.en),
			.waddr (wr.addr),
			.wdata (wr.data),
			.re    (re),
			.raddr (raddr[c]),
			.rdata (ram_data[c])
		);
		assign rdata[c] = hit_q[c] ? ram_data[c] : rom_q[c];
	end

	// An entry reads from RAM only once it has been written since reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr.en) begin
			valid_q[wr.addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			for (int c = 0; c < 3; c++) begin
				hit_q[c] <= valid_q[raddr[c]];
				rom_q[c] <= lpc_pkg::GAMMA_ROM[raddr[c]];
			end
		end
	end

endmodule

@@ tb/led_pixel_correction_pipeline_test.sv @@
// Self-checking test of led_pixel_correction_pipeline: pixel and gamma table
// words in, corrected pixels out, compared against an in-bench pixel model.
// Depends on lpc_pkg, the lpc_*_if interfaces and the pipeline top level.
`timescale 1ns / 1ps

module led_pixel_correction_pipeline_test;
	import lpc_pkg::*;

	localparam logic KIND_PIXEL    = 1'b0;
	localparam logic KIND_GAMMA_WR = 1'b1;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;
	localparam int SPREAD       = 40;
	localparam int PCT_FULL     = 100;
	localparam int PHASES       = 8;
	localparam int PHASE_WORDS  = 150;
	localparam int QUIET_LIMIT  = 1000;
	localparam int PIPE_SETTLE  = 20;

	typedef struct packed {
		logic [CHAN_W-1:0] r;
		logic [CHAN_W-1:0] g;
		logic [CHAN_W-1:0] b;
		logic              fe;
	} shade_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	lpc_in_if  in_ch ();
	lpc_out_if out_ch ();
	lpc_cfg_if cfg_ch ();

	led_pixel_correction_pipeline DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.pixel_in  (in_ch),
		.pixel_out (out_ch),
		.cfg       (cfg_ch)
	);

	// Bench-side drive registers, known from time zero.
	logic                  in_valid = 1'b0;
	item_t                 in_word = '0;
	logic                  out_ready = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	assign in_ch.valid        = in_valid;
	assign in_ch.kind         = in_word.kind;
	assign in_ch.red_in       = in_word.r;
	assign in_ch.green_in     = in_word.g;
	assign in_ch.blue_in      = in_word.b;
	assign in_ch.frame_end_in = in_word.fe;
	assign in_ch.table_index  = in_word.idx;
	assign in_ch.table_value  = in_word.val;
	assign out_ch.ready       = out_ready;
	assign cfg_ch.valid       = cfg_valid;
	assign cfg_ch.index       = cfg_idx;
	assign cfg_ch.data        = cfg_data;

	// Pixel model state.
	logic [ENABLE_W-1:0] stage_en;
	logic [CHAN_W-1:0]   max_bright;
	logic [CHAN_W-1:0]   white_thr;
	logic [CHAN_W-1:0]   white_tgt;
	logic [PCT_W-1:0]    green_pct;
	logic [PCT_W-1:0]    blue_pct;
	logic [CHAN_W-1:0]   curve [GAMMA_DEPTH];

	item_t  pixel_words [$];
	shade_t corrected_q [$];
	logic   calm = 1'b0;
	int     mismatches = 0;
	int     px_seen = 0;
	int     gap_left = 0;
	int     stall_left = 0;
	int     quiet = 0;
	shade_t got_px;
	shade_t want_px;

	initial begin
		forever #5 clk = ~clk;
	end

	// True when (2k-1)^5 * 255^6 <= lim, i.e. the k-th half step lies under the curve.
	function automatic bit odd_fits(int unsigned k, logic [127:0] lim);
		logic [127:0] v;
		int n;
		v = 128'd274941996890625;
		for (n = 0; n < 5; n++)
			v = v * (2 * k - 1);
		return v <= lim;
	endfunction

	// Start from a floating-point estimate, then settle the entry exactly so
	// that values sitting on a half step round up.
	function automatic logic [CHAN_W-1:0] gamma22_entry(int unsigned i);
		logic [127:0] lim;
		int e;
		int n;
		lim = 128'd32;
		for (n = 0; n < 11; n++)
			lim = lim * i;
		e = $rtoi(255.0 * $pow(i / 255.0, 2.2) + 0.5);
		if (e > 255)
			e = 255;
		while (e < 255 && odd_fits(e + 1, lim))
			e++;
		while (e > 0 && !odd_fits(e, lim))
			e--;
		return CHAN_W'(e);
	endfunction

	function automatic shade_t correct_pixel(item_t w);
		int unsigned r, g, b, hi, lo, s, d, cap_g, cap_b;
		shade_t o;
		r = w.r;
		g = w.g;
		b = w.b;
		if (stage_en[EN_CLAMP]) begin
			hi = (r > g) ? r : g;
			hi = (hi > b) ? hi : b;
			if (max_bright < 255 && hi > max_bright) begin
				s = (max_bright * 256) / hi;
				r = (r * s) >> 8;
				g = (g * s) >> 8;
				b = (b * s) >> 8;
			end
		end
		if (stage_en[EN_WHITE]) begin
			hi = (r > g) ? r : g;
			hi = (hi > b) ? hi : b;
			lo = (r < g) ? r : g;
			lo = (lo < b) ? lo : b;
			if (lo > white_thr && hi - lo < SPREAD && lo > white_tgt) begin
				d = lo - white_tgt;
				r = (r > d) ? r - d : 0;
				g = (g > d) ? g - d : 0;
				b = (b > d) ? b - d : 0;
			end
		end
		if (stage_en[EN_BROWN]) begin
			if (r > g && g >= b) begin
				cap_g = r * green_pct / PCT_FULL;
				cap_b = r * blue_pct / PCT_FULL;
				if (cap_g > 255)
					cap_g = 255;
				if (cap_b > 255)
					cap_b = 255;
				if (g > cap_g)
					g = cap_g;
				if (b > cap_b)
					b = cap_b;
			end
		end
		if (stage_en[EN_GAMMA]) begin
			r = curve[r];
			g = curve[g];
			b = curve[b];
		end
		o.r = CHAN_W'(r);
		o.g = CHAN_W'(g);
		o.b = CHAN_W'(b);
		o.fe = w.fe;
		return o;
	endfunction

	function automatic item_t word_of(logic kind, int r, int g, int b, logic fe, int idx, int val);
		item_t w;
		w.kind = kind;
		w.r = CHAN_W'(r);
		w.g = CHAN_W'(g);
		w.b = CHAN_W'(b);
		w.fe = fe;
		w.idx = CHAN_W'(idx);
		w.val = CHAN_W'(val);
		return w;
	endfunction

	function automatic int edge_value();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 1;
			2: return 127;
			3: return 128;
			4: return 254;
			default: return 255;
		endcase
	endfunction

	// Mostly pixels, some shaped to reach the white and brown paths, others at
	// edge values or with one channel at full scale, with table rewrites mixed in.
	function automatic item_t pick_word();
		item_t w;
		int base, r, g, b;
		w = word_of(KIND_PIXEL, $urandom, $urandom, $urandom, $urandom_range(0, 7) == 0,
			$urandom, $urandom);
		if ($urandom_range(0, 7) == 0) begin
			w.kind = KIND_GAMMA_WR;
			w.fe = 1'($urandom_range(0, 1));
			return w;
		end
		case ($urandom_range(0, 4))
			0: ;
			1: begin
				base = $urandom_range(100, 255);
				r = base - $urandom_range(0, 45);
				g = base - $urandom_range(0, 45);
				b = base - $urandom_range(0, 45);
				w.r = CHAN_W'(r);
				w.g = CHAN_W'(g);
				w.b = CHAN_W'(b);
			end
			2: begin
				r = $urandom_range(1, 255);
				g = $urandom_range(0, r - 1);
				b = $urandom_range(0, g);
				w.r = CHAN_W'(r);
				w.g = CHAN_W'(g);
				w.b = CHAN_W'(b);
			end
			3: begin
				w.r = CHAN_W'(edge_value());
				w.g = CHAN_W'(edge_value());
				w.b = CHAN_W'(edge_value());
			end
			default: begin
				case ($urandom_range(0, 2))
					0: w.r = CHAN_MAX;
					1: w.g = CHAN_MAX;
					default: w.b = CHAN_MAX;
				endcase
			end
		endcase
		return w;
	endfunction

	task automatic flag_mismatch(string msg);
		$display("mismatch at pixel %0d: %s", px_seen, msg);
		mismatches++;
	endtask

	task automatic check_chan(string name, logic [CHAN_W-1:0] got, logic [CHAN_W-1:0] want);
		if (got !== want)
			flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ch.ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			REG_STAGE_ENABLES:   stage_en = data[ENABLE_W-1:0];
			REG_MAX_BRIGHTNESS:  max_bright = data;
			REG_WHITE_THRESHOLD: white_thr = data;
			REG_WHITE_TARGET:    white_tgt = data;
			REG_GREEN_PERCENT:   green_pct = data[PCT_W-1:0];
			REG_BLUE_PERCENT:    blue_pct = data[PCT_W-1:0];
			default: ;
		endcase
	endtask

	// Unused upper data bits are filled at random; the block must drop them.
	task automatic write_all(int en, int mb, int wth, int wtg, int gp, int bp);
		write_reg(REG_STAGE_ENABLES, {4'($urandom), 4'(en)});
		write_reg(REG_MAX_BRIGHTNESS, 8'(mb));
		write_reg(REG_WHITE_THRESHOLD, 8'(wth));
		write_reg(REG_WHITE_TARGET, 8'(wtg));
		write_reg(REG_GREEN_PERCENT, {1'($urandom), 7'(gp)});
		write_reg(REG_BLUE_PERCENT, {1'($urandom), 7'(bp)});
	endtask

	task automatic wait_drained();
		while (pixel_words.size() != 0 || in_valid || corrected_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : stimulus
		int p, n;
		stage_en = 4'd11;
		max_bright = 8'd255;
		white_thr = 8'd150;
		white_tgt = 8'd100;
		green_pct = 7'd28;
		blue_pct = 7'd8;
		for (n = 0; n < GAMMA_DEPTH; n++)
			curve[n] = gamma22_entry(n);
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words under the reset settings.
		pixel_words.push_back(word_of(KIND_PIXEL, 0, 0, 0, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 255, 255, 255, 1'b1, 255, 255));
		pixel_words.push_back(word_of(KIND_PIXEL, 200, 150, 10, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 151, 151, 151, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 150, 150, 150, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 160, 199, 170, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 160, 200, 170, 1'b1, 0, 0));
		pixel_words.push_back(word_of(KIND_GAMMA_WR, 0, 0, 0, 1'b0, 0, 255));
		pixel_words.push_back(word_of(KIND_PIXEL, 0, 0, 0, 1'b0, 0, 0));
		pixel_words.push_back(word_of(KIND_GAMMA_WR, 255, 255, 255, 1'b1, 255, 0));
		pixel_words.push_back(word_of(KIND_PIXEL, 255, 0, 0, 1'b1, 0, 0));
		pixel_words.push_back(word_of(KIND_GAMMA_WR, 17, 34, 51, 1'b0, 100, 7));
		pixel_words.push_back(word_of(KIND_PIXEL, 255, 255, 255, 1'b0, 100, 7));
		// Table fields on a pixel word are don't-care.
		pixel_words.push_back(word_of(KIND_PIXEL, 1, 2, 3, 1'b0, 200, 9));
		pixel_words.push_back(word_of(KIND_PIXEL, 0, 255, 128, 1'b1, 127, 128));

		for (p = 0; p < PHASES; p++) begin
			if (p != 0) begin
				wait_drained();
				repeat (PIPE_SETTLE) @(posedge clk);
				case (p)
					1: write_all(15, 200, 100, 50, 50, 20);
					2: write_all(0, $urandom, $urandom, $urandom, $urandom_range(0, 127),
						$urandom_range(0, 127));
					3: write_all(15, 0, 0, 0, 0, 0);
					4: write_all(15, 254, 255, 255, 100, 100);
					5: write_all(7, 128, 150, 200, 127, 127);
					6: begin
						write_all($urandom_range(0, 15), $urandom, $urandom_range(0, 200),
							$urandom, $urandom_range(0, 127), $urandom_range(0, 127));
						write_reg(REG_SPARE_6, 8'($urandom));
						write_reg(REG_SPARE_7, 8'($urandom));
					end
					default: write_all(15, $urandom_range(100, 254), $urandom_range(80, 200),
						$urandom_range(0, 180), $urandom_range(0, 127), $urandom_range(0, 127));
				endcase
				if (p == 1) begin
					pixel_words.push_back(word_of(KIND_PIXEL, 255, 0, 0, 1'b0, 0, 0));
					pixel_words.push_back(word_of(KIND_PIXEL, 201, 201, 201, 1'b0, 0, 0));
					pixel_words.push_back(word_of(KIND_PIXEL, 200, 150, 10, 1'b1, 0, 0));
				end
			end
			if (p == PHASES - 1)
				calm = 1'b1;
			for (n = 0; n < PHASE_WORDS; n++)
				pixel_words.push_back(pick_word());
		end

		wait_drained();
		repeat (30) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// Pixel word driver; also feeds the pixel model on each accepted word.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ch.ready) begin
				if (in_word.kind == KIND_GAMMA_WR)
					curve[in_word.idx] = in_word.val;
				else
					corrected_q.push_back(correct_pixel(in_word));
			end
			if (!in_valid || in_ch.ready) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (!calm && $urandom_range(0, 5) == 0) begin
					gap_left = $urandom_range(0, 7);
					in_valid <= 1'b0;
				end else if (pixel_words.size() != 0) begin
					in_word <= pixel_words.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Corrected pixel monitor with random backpressure.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_ch.valid && out_ready) begin
				got_px.r = out_ch.red_out;
				got_px.g = out_ch.green_out;
				got_px.b = out_ch.blue_out;
				got_px.fe = out_ch.frame_end_out;
				if (corrected_q.size() == 0) begin
					flag_mismatch("corrected pixel with none outstanding");
				end else begin
					want_px = corrected_q.pop_front();
					check_chan("red", got_px.r, want_px.r);
					check_chan("green", got_px.g, want_px.g);
					check_chan("blue", got_px.b, want_px.b);
					if (got_px.fe !== want_px.fe)
						flag_mismatch($sformatf("frame_end got %b want %b", got_px.fe, want_px.fe));
				end
				px_seen++;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (!calm && $urandom_range(0, 5) == 0) begin
				stall_left = $urandom_range(0, 7);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Watchdog: ends the run if no word moves on any channel for too long.
	always @(posedge clk) begin
		if ((in_valid && in_ch.ready) || (out_ch.valid && out_ready) || (cfg_valid && cfg_ch.ready))
			quiet = 0;
		else
			quiet++;
		if (quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

endmodule
